// ----- rtl/core/hcfp_pkg.sv -----
// ----------------------------------------------------------------------------
// hcfp_pkg
// Shared types and constants for the host command frame parser.
// ----------------------------------------------------------------------------
package hcfp_pkg;

  // Frame layout: start, mode, six velocity bytes, checksum
  localparam int unsigned FrameLength  = 9;
  localparam int unsigned PayloadBytes = 7;
  localparam int unsigned PosWidth     = 4;

  // Position codes: hunting, then count of frame bytes taken
  localparam logic [PosWidth-1:0] PosHunt  = PosWidth'(0);
  localparam logic [PosWidth-1:0] PosCheck = PosWidth'(FrameLength - 1);

  localparam logic [7:0] StartByteReset = 8'hA5;

  typedef logic [7:0] byte_t;

  // Decoded frame from the deframer to the result stage
  typedef struct packed {
    logic               good;
    byte_t              mode;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] yaw;
  } hcfp_frame_t;

endpackage

// ----- rtl/core/hcfp_deframer.sv -----
// ----------------------------------------------------------------------------
// hcfp_deframer
// Hunts for the start byte, collects the payload, checks the additive sum.
// ----------------------------------------------------------------------------
module hcfp_deframer import hcfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        byte_take_i,
  input  byte_t       byte_i,
  input  byte_t       start_byte_i,
  output hcfp_frame_t frame_o
);

  logic [PosWidth-1:0] pos_q, pos_d;
  byte_t               sum_q, sum_d;
  byte_t               payload_q [PayloadBytes];

  logic in_payload;
  assign in_payload = (pos_q != PosHunt) && (pos_q != PosCheck);

  always_comb begin
    pos_d = pos_q;
    sum_d = sum_q;
    if (byte_take_i) begin
      if (pos_q == PosHunt) begin
        if (byte_i == start_byte_i) begin
          pos_d = PosWidth'(1);
          sum_d = byte_i;
        end
      end else if (in_payload) begin
        pos_d = pos_q + PosWidth'(1);
        sum_d = sum_q + byte_i;
      end else begin
        pos_d = PosHunt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosHunt;
      sum_q <= '0;
    end else begin
      pos_q <= pos_d;
      sum_q <= sum_d;
    end
  end

  // payload shift line, oldest word (mode) ends up at index 0
  always_ff @(posedge clk_i) begin
    if (byte_take_i && in_payload) begin
      for (int i = 0; i < PayloadBytes - 1; i++) begin
        payload_q[i] <= payload_q[i+1];
      end
      payload_q[PayloadBytes-1] <= byte_i;
    end
  end

  always_comb begin
    frame_o.good  = byte_take_i && (pos_q == PosCheck) && (byte_i == sum_q);
    frame_o.mode  = payload_q[0];
    frame_o.vel_x = {payload_q[2], payload_q[1]};
    frame_o.vel_y = {payload_q[4], payload_q[3]};
    frame_o.yaw   = {payload_q[6], payload_q[5]};
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosCheck)
    else $error("frame position out of range");

  a_check_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_take_i && pos_q == PosCheck) |=> pos_q == PosHunt)
    else $error("checksum word did not end the frame");

  a_good_only_at_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_o.good |-> (pos_q == PosCheck) && byte_take_i)
    else $error("frame flagged good outside checksum slot");

endmodule

// ----- rtl/core/host_command_frame_parser_core.sv -----
// ----------------------------------------------------------------------------
// host_command_frame_parser_core
// Byte-stream deframer for nine-word host command frames.
// ----------------------------------------------------------------------------
// Takes one received word per cycle on rx_*; it is ready whenever the result
// register is empty or being drained, so a stalled output holds the link only
// while a finished frame is still waiting. Words before a start byte are
// dropped; a frame whose checksum word differs from the low byte of the sum
// of its first eight words is dropped silently. A good frame appears on out_*
// in the cycle after its checksum word is accepted, with frames_accepted_o
// counting good frames including itself (wraps). start_byte_i (reset 0xA5) is
// written through cfg_*, always ready, and applies from the next hunt.
module host_command_frame_parser_core import hcfp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         start_byte_i,
  // received words
  input  logic               rx_valid_i,
  output logic               rx_ready_o,
  input  logic [7:0]         rx_byte_i,
  // decoded frames
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         mode_request_o,
  output logic signed [15:0] vel_x_o,
  output logic signed [15:0] vel_y_o,
  output logic signed [15:0] yaw_rate_o,
  output logic [31:0]        frames_accepted_o
);

  byte_t              start_q;
  logic               out_valid_q, out_valid_d;
  logic [31:0]        count_q;
  byte_t              mode_q;
  logic signed [15:0] vel_x_q, vel_y_q, yaw_q;
  hcfp_frame_t        frame;
  logic               rx_take;

  assign cfg_ready_o = 1'b1;
  assign rx_ready_o  = !out_valid_q || out_ready_i;
  assign rx_take     = rx_valid_i && rx_ready_o;

  hcfp_deframer u_deframer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_take_i  (rx_take),
    .byte_i       (rx_byte_i),
    .start_byte_i (start_q),
    .frame_o      (frame)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (frame.good)  out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= StartByteReset;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      if (cfg_valid_i) start_q <= start_byte_i;
      out_valid_q <= out_valid_d;
      if (frame.good) count_q <= count_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame.good) begin
      mode_q  <= frame.mode;
      vel_x_q <= frame.vel_x;
      vel_y_q <= frame.vel_y;
      yaw_q   <= frame.yaw;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign mode_request_o    = mode_q;
  assign vel_x_o           = vel_x_q;
  assign vel_y_o           = vel_y_q;
  assign yaw_rate_o        = yaw_q;
  assign frames_accepted_o = count_q;

  a_good_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame.good |-> (!out_valid_q || out_ready_i))
    else $error("good frame would overwrite an unread result");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame.good |=> count_q == $past(count_q) + 32'd1)
    else $error("frame count did not advance on a good frame");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !frame.good |=> $stable(count_q))
    else $error("frame count changed without a good frame");

  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame.good |=> out_valid_q)
    else $error("good frame not presented");

endmodule
